[hdl/bps_pkg.sv]
package bps_pkg;

  // Event codes carried by the action field.
  localparam logic [1:0] ACT_TICK    = 2'd0;
  localparam logic [1:0] ACT_SLOW    = 2'd1;
  localparam logic [1:0] ACT_RESTART = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_MODE     = 3'd0;
  localparam logic [2:0] REG_GRAVITY  = 3'd1;
  localparam logic [2:0] REG_FRICTION = 3'd2;
  localparam logic [2:0] REG_RUBBER   = 3'd3;
  localparam logic [2:0] REG_VLIMIT   = 3'd4;

  // Bit positions inside mode_flags.
  localparam int MODE_FRICTION = 0;
  localparam int MODE_ANTIGRAV = 1;
  localparam int MODE_RUBBER   = 2;
  localparam int MODE_PAUSED   = 3;

  // Q16.8 constants: wall at 500 and recentring bound at 10000.
  localparam logic signed [23:0] WALL_Q  = 24'sd128000;
  localparam logic [25:0]        BOUND_Q = 26'd2560000;

  localparam logic signed [23:0] S24_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] S24_MIN = 24'sh800000;

  typedef struct packed {
    logic [3:0]  mode_flags;
    logic [15:0] gravity_step;
    logic [8:0]  friction_factor;
    logic [15:0] rubber_gain;
    logic [22:0] velocity_limit;
  } cfg_t;

  // Saturate a wide signed value to the signed 24-bit range.
  function automatic logic signed [23:0] sat24(input logic signed [34:0] v);
    logic signed [23:0] r;
    if (v > 35'sd8388607) begin
      r = S24_MAX;
    end else if (v < -35'sd8388608) begin
      r = S24_MIN;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

  // Negation with the most negative value mapped to the most positive one.
  function automatic logic signed [23:0] neg24(input logic signed [23:0] v);
    logic signed [23:0] r;
    if (v == S24_MIN) begin
      r = S24_MAX;
    end else begin
      r = -v;
    end
    return r;
  endfunction

  // Magnitude of a signed 24-bit value; the most negative value fits unsigned.
  function automatic logic [23:0] abs24(input logic signed [23:0] v);
    logic [23:0] r;
    if (v[23]) begin
      r = ~v + 24'd1;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

[hdl/bouncing_particle_step_top.sv]
// Fixed-point step of one bouncing particle. Each input transaction carries
// an event: a tick moves the particle by velocity times speed, bounces it off
// the walls, floor and ceiling, applies friction, rubber gain, the y velocity
// clamp, recentring and gravity; a slow-down scales the speed by the gravity
// register; a restart loads a new motion. Every event yields exactly one
// output transaction holding the full state after it. Friction applies only
// when the floor is hit with friction enabled, rubber gain only with rubber
// set, gravity only without anti-gravity, and a paused tick leaves the state
// unchanged. All products go through one shared multiplier with a registered
// output, sequenced by a small state machine. A finished result sits in an
// output register, so the next input transaction can be accepted while it
// waits. Configuration writes must only happen while the block is idle.
module bouncing_particle_step_top (
  input  logic               clk,
  input  logic               rst,

  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         action,
  input  logic signed [23:0] new_vel_x,
  input  logic signed [23:0] new_vel_y,
  input  logic signed [23:0] new_vel_z,
  input  logic [15:0]        new_speed,

  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [23:0] pos_x,
  output logic signed [23:0] pos_y,
  output logic signed [23:0] pos_z,
  output logic signed [23:0] vel_x,
  output logic signed [23:0] vel_y,
  output logic signed [23:0] vel_z,
  output logic [15:0]        speed_now,
  output logic [15:0]        age_ticks,

  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [22:0]        cfg_data
);

  // Sequencer states. The MOVE, FRIC and RUB steps issue products to the shared
  // multiplier; each product is collected in the step after the one that issued it.
  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_SLOW0 = 5'd1;
  localparam logic [4:0] ST_SLOW1 = 5'd2;
  localparam logic [4:0] ST_MOVE0 = 5'd3;
  localparam logic [4:0] ST_MOVE1 = 5'd4;
  localparam logic [4:0] ST_MOVE2 = 5'd5;
  localparam logic [4:0] ST_MOVE3 = 5'd6;
  localparam logic [4:0] ST_WALL  = 5'd7;
  localparam logic [4:0] ST_FRIC0 = 5'd8;
  localparam logic [4:0] ST_FRIC1 = 5'd9;
  localparam logic [4:0] ST_FRIC2 = 5'd10;
  localparam logic [4:0] ST_FRIC3 = 5'd11;
  localparam logic [4:0] ST_RUB0  = 5'd12;
  localparam logic [4:0] ST_RUB1  = 5'd13;
  localparam logic [4:0] ST_CLAMP = 5'd14;
  localparam logic [4:0] ST_GRAV  = 5'd15;
  localparam logic [4:0] ST_DONE  = 5'd16;

  bps_pkg::cfg_t cfg;

  logic [4:0]         state;
  logic signed [23:0] pos [3];
  logic signed [23:0] vel [3];
  logic [15:0]        speed_factor;
  logic [15:0]        age_count;
  logic [25:0]        abs_sum;

  logic               in_accept;
  logic               out_free;

  logic signed [24:0] mul_a;
  logic [15:0]        mul_b;
  logic signed [33:0] mul_raw;
  logic signed [23:0] mul_s24;
  logic [15:0]        mul_u16;

  logic signed [34:0] pos_sum;
  logic signed [23:0] pos_target;
  logic signed [24:0] vy_ext;
  logic signed [24:0] lim_ext;
  logic signed [24:0] vy_grav;

  bps_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bps_mul u_mul (
    .clk      (clk),
    .a        (mul_a),
    .b        (mul_b),
    .prod_q   (mul_raw),
    .prod_s24 (mul_s24),
    .prod_u16 (mul_u16)
  );

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  // The output register can take a new result when empty or being drained.
  assign out_free  = !out_valid || !out_stall;

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = {vel[0][23], vel[0]};
    mul_b = speed_factor;
    case (state)
      ST_SLOW0: begin
        mul_a = {9'd0, speed_factor};
        mul_b = cfg.gravity_step;
      end
      ST_MOVE0: mul_a = {vel[0][23], vel[0]};
      ST_MOVE1: mul_a = {vel[1][23], vel[1]};
      ST_MOVE2: mul_a = {vel[2][23], vel[2]};
      ST_FRIC0: begin
        mul_a = {vel[0][23], vel[0]};
        mul_b = {7'd0, cfg.friction_factor};
      end
      ST_FRIC1: begin
        mul_a = {vel[1][23], vel[1]};
        mul_b = {7'd0, cfg.friction_factor};
      end
      ST_FRIC2: begin
        mul_a = {vel[2][23], vel[2]};
        mul_b = {7'd0, cfg.friction_factor};
      end
      ST_RUB0: begin
        mul_a = {vel[1][23], vel[1]};
        mul_b = cfg.rubber_gain;
      end
      default: ;
    endcase
  end

  // Position update uses the unsaturated product, saturating only the sum.
  always_comb begin
    case (state)
      ST_MOVE2: pos_target = pos[1];
      ST_MOVE3: pos_target = pos[2];
      default:  pos_target = pos[0];
    endcase
    pos_sum = {{11{pos_target[23]}}, pos_target} + {mul_raw[33], mul_raw};
  end

  assign vy_ext  = {vel[1][23], vel[1]};
  assign lim_ext = $signed({2'b00, cfg.velocity_limit});
  assign vy_grav = vy_ext - $signed({9'd0, cfg.gravity_step});

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      pos[0]       <= '0;
      pos[1]       <= '0;
      pos[2]       <= '0;
      vel[0]       <= '0;
      vel[1]       <= '0;
      vel[2]       <= '0;
      speed_factor <= 16'd256;
      age_count    <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_accept) begin
            case (action)
              bps_pkg::ACT_TICK: begin
                if (cfg.mode_flags[bps_pkg::MODE_PAUSED]) begin
                  state <= ST_DONE;
                end else begin
                  state <= ST_MOVE0;
                end
              end
              bps_pkg::ACT_SLOW: state <= ST_SLOW0;
              bps_pkg::ACT_RESTART: begin
                vel[0]       <= new_vel_x;
                vel[1]       <= new_vel_y;
                vel[2]       <= new_vel_z;
                speed_factor <= new_speed;
                pos[0]       <= '0;
                pos[1]       <= '0;
                pos[2]       <= '0;
                age_count    <= '0;
                state        <= ST_DONE;
              end
              default: state <= ST_DONE;
            endcase
          end
        end

        ST_SLOW0: state <= ST_SLOW1;
        ST_SLOW1: begin
          speed_factor <= mul_u16;
          state        <= ST_DONE;
        end

        ST_MOVE0: begin
          if (age_count != 16'hFFFF) begin
            age_count <= age_count + 16'd1;
          end
          state <= ST_MOVE1;
        end
        ST_MOVE1: begin
          pos[0] <= bps_pkg::sat24(pos_sum);
          state  <= ST_MOVE2;
        end
        ST_MOVE2: begin
          pos[1] <= bps_pkg::sat24(pos_sum);
          state  <= ST_MOVE3;
        end
        ST_MOVE3: begin
          pos[2] <= bps_pkg::sat24(pos_sum);
          state  <= ST_WALL;
        end

        // Wall, floor and ceiling reflections.
        ST_WALL: begin
          if (pos[2] <= -bps_pkg::WALL_Q || pos[2] >= bps_pkg::WALL_Q) begin
            vel[2] <= bps_pkg::neg24(vel[2]);
          end
          if (pos[0] <= -bps_pkg::WALL_Q || pos[0] >= bps_pkg::WALL_Q) begin
            vel[0] <= bps_pkg::neg24(vel[0]);
          end
          if (pos[1] < 0 || pos[1] >= bps_pkg::WALL_Q) begin
            vel[1] <= bps_pkg::neg24(vel[1]);
          end
          if (pos[1] < 0 || pos[1] > bps_pkg::WALL_Q) begin
            pos[1] <= '0;
          end
          if (pos[1] < 0 && cfg.mode_flags[bps_pkg::MODE_FRICTION]) begin
            state <= ST_FRIC0;
          end else if (cfg.mode_flags[bps_pkg::MODE_RUBBER]) begin
            state <= ST_RUB0;
          end else begin
            state <= ST_CLAMP;
          end
        end

        ST_FRIC0: state <= ST_FRIC1;
        ST_FRIC1: begin
          vel[0] <= mul_s24;
          state  <= ST_FRIC2;
        end
        ST_FRIC2: begin
          vel[1] <= mul_s24;
          state  <= ST_FRIC3;
        end
        ST_FRIC3: begin
          vel[2] <= mul_s24;
          if (cfg.mode_flags[bps_pkg::MODE_RUBBER]) begin
            state <= ST_RUB0;
          end else begin
            state <= ST_CLAMP;
          end
        end

        ST_RUB0: state <= ST_RUB1;
        ST_RUB1: begin
          vel[1] <= mul_s24;
          state  <= ST_CLAMP;
        end

        // Clamp y velocity and form the Manhattan distance for recentring.
        ST_CLAMP: begin
          if (vy_ext > lim_ext) begin
            vel[1] <= lim_ext[23:0];
          end else if (vy_ext < -lim_ext) begin
            vel[1] <= 24'(-lim_ext);
          end
          abs_sum <= {2'b00, bps_pkg::abs24(pos[0])}
                   + {2'b00, bps_pkg::abs24(pos[1])}
                   + {2'b00, bps_pkg::abs24(pos[2])};
          state   <= ST_GRAV;
        end

        ST_GRAV: begin
          if (abs_sum > bps_pkg::BOUND_Q) begin
            pos[0] <= '0;
            pos[1] <= '0;
            pos[2] <= '0;
          end
          if (!cfg.mode_flags[bps_pkg::MODE_ANTIGRAV]) begin
            vel[1] <= bps_pkg::sat24({{10{vy_grav[24]}}, vy_grav});
          end
          state <= ST_DONE;
        end

        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  // Output register; loaded only when the previous transaction has left or is leaving.
  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      pos_x     <= pos[0];
      pos_y     <= pos[1];
      pos_z     <= pos[2];
      vel_x     <= vel[0];
      vel_y     <= vel[1];
      vel_z     <= vel[2];
      speed_now <= speed_factor;
      age_ticks <= age_count;
    end
  end

endmodule

[hdl/bps_cfg.sv]
module bps_cfg (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [22:0]        cfg_data,
  output bps_pkg::cfg_t      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode_flags      <= 4'd0;
      cfg.gravity_step    <= 16'd36;
      cfg.friction_factor <= 9'd166;
      cfg.rubber_gain     <= 16'd396;
      cfg.velocity_limit  <= 23'd32000;
    end else if (cfg_write) begin
      case (cfg_index)
        bps_pkg::REG_MODE:     cfg.mode_flags      <= cfg_data[3:0];
        bps_pkg::REG_GRAVITY:  cfg.gravity_step    <= cfg_data[15:0];
        bps_pkg::REG_FRICTION: cfg.friction_factor <= cfg_data[8:0];
        bps_pkg::REG_RUBBER:   cfg.rubber_gain     <= cfg_data[15:0];
        bps_pkg::REG_VLIMIT:   cfg.velocity_limit  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

[hdl/bps_mul.sv]
module bps_mul (
  input  logic               clk,
  input  logic signed [24:0] a,
  input  logic [15:0]        b,
  output logic signed [33:0] prod_q,
  output logic signed [23:0] prod_s24,
  output logic [15:0]        prod_u16
);

  // Signed times unsigned Q8.8; dropping the low 8 bits of the two's
  // complement product rounds toward minus infinity.
  logic signed [41:0] full;

  assign full = a * $signed({1'b0, b});

  always_ff @(posedge clk) begin
    prod_q <= full[41:8];
  end

  assign prod_s24 = bps_pkg::sat24({prod_q[33], prod_q});
  assign prod_u16 = (|prod_q[33:16]) ? 16'hFFFF : prod_q[15:0];

endmodule
